// File: rtl/core/spm_pkg.sv
// spm_pkg: shared constants, types and helpers for the spin-one Metropolis block.
// Used by spm_ctrl, spm_dp and the top level; no dependencies.
`default_nettype none

package spm_pkg;

  // Lattice geometry
  localparam int LATTICE_SIDE = 64;
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int ADDR_W       = $clog2(SITE_COUNT);
  localparam int COL_W        = $clog2(LATTICE_SIDE);

  // Field widths of the ports
  localparam int SITE_W      = 12;
  localparam int SPIN_W      = 2;
  localparam int BUDGET_W    = 16;
  localparam int CF_W        = 16;
  localparam int BOND_OUT_W  = 15;
  localparam int MAG_OUT_W   = 14;
  localparam int SQ_OUT_W    = 13;
  localparam int TOT_OUT_W   = 29;

  // Internal running sums, wide enough for any lattice size
  localparam int BOND_W    = ADDR_W + 3;
  localparam int MAG_W     = ADDR_W + 2;
  localparam int SQ_W      = ADDR_W + 1;
  localparam int TOT_INT_W = ((BOND_W + 8) > (SQ_W + CF_W + 1) ?
                              (BOND_W + 8) : (SQ_W + CF_W + 1)) + 1;
  // Energy change in Q11.8: bond part within +-8*256, field part within +-2^15
  localparam int DE_W      = 19;

  localparam logic signed [BOND_W-1:0] BOND_RST = BOND_W'(-2 * SITE_COUNT);
  localparam logic signed [MAG_W-1:0]  MAG_RST  = MAG_W'(SITE_COUNT);
  localparam logic [SQ_W-1:0]          SQ_RST   = SQ_W'(SITE_COUNT);

  // Row split by reciprocal multiply: row = (site * RECIP) >> DIV_K
  localparam int DIV_K   = 24;
  localparam int RECIP_W = DIV_K + 1;
  localparam int RECIP   = (1 << DIV_K) / LATTICE_SIDE + 1;

  localparam logic signed [SPIN_W-1:0] SPIN_UP     = 2'sb01;
  localparam logic signed [SPIN_W-1:0] SPIN_UNUSED = 2'sb10;

  // Proposal per old spin (-1, 0, +1) and pick
  localparam logic signed [SPIN_W-1:0] PICK_TABLE [3][2] = '{
    '{ 2'sb01, 2'sb00},
    '{ 2'sb01, 2'sb11},
    '{ 2'sb11, 2'sb00}
  };

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_RD_DN,
    ST_RD_LF,
    ST_RD_RT,
    ST_EVAL,
    ST_COMMIT,
    ST_TOTAL
  } state_e;

  typedef enum logic [2:0] {
    RD_SITE,
    RD_UP,
    RD_DN,
    RD_LF,
    RD_RT
  } rd_sel_e;

  typedef struct packed {
    logic              load;
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
    logic              rd_en;
    rd_sel_e           rd_sel;
    logic              div;
    logic              mod;
    logic              commit;
    logic              out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_range;
  } dp_status_t;

  function automatic logic signed [SPIN_W-1:0] pick_spin(
    input logic signed [SPIN_W-1:0] cur_spin,
    input logic                     pick
  );
    logic [1:0] idx;
    idx = 2'(cur_spin) + 2'd1;
    if (idx == 2'd3) begin
      return 2'sb00;
    end
    return PICK_TABLE[idx][pick];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/spin_one_metropolis_update_top.sv
// Top level of the spin-one Metropolis update block: spm_ctrl plus spm_dp.
// Depends on spm_pkg, spm_ctrl and spm_dp.
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------------
//  in      | in_valid_i / in_stall_o    | action, site, proposal_pick, new_value, budget
//  out     | out_valid_o / out_stall_i  | accepted, site_spin, sums, total_energy
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_crystal_field_i
//
// A request goes from accept through DIV, MOD, RD_DN, RD_LF, RD_RT, EVAL, COMMIT and
// TOTAL to the result load (an out-of-range site: DIV, then TOTAL), set by the five
// reads of the single-read-port lattice memory plus write-back; TOTAL waits on a stalled
// result; a new request is taken only in IDLE. Config writes are taken at any time.
// After reset a clearing pass sets all SITE_COUNT sites to +1, with in_stall_o high.
// A finished result waits in the output register while the next request is accepted.
`default_nettype none

module spin_one_metropolis_update_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 action_i,
  input  wire logic [spm_pkg::SITE_W-1:0]           site_i,
  input  wire logic                                 proposal_pick_i,
  input  wire logic signed [spm_pkg::SPIN_W-1:0]    new_value_i,
  input  wire logic [spm_pkg::BUDGET_W-1:0]         accept_budget_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      accepted_o,
  output logic signed [spm_pkg::SPIN_W-1:0]         site_spin_o,
  output logic signed [spm_pkg::BOND_OUT_W-1:0]     bond_energy_o,
  output logic signed [spm_pkg::MAG_OUT_W-1:0]      magnet_total_o,
  output logic [spm_pkg::SQ_OUT_W-1:0]              square_total_o,
  output logic signed [spm_pkg::TOT_OUT_W-1:0]      total_energy_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic signed [spm_pkg::CF_W-1:0]      cfg_crystal_field_i
);

  spm_pkg::ctrl_cmd_t  cmd;
  spm_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  spm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spm_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_crystal_field_i (cfg_crystal_field_i),
    .action_i            (action_i),
    .site_i              (site_i),
    .proposal_pick_i     (proposal_pick_i),
    .new_value_i         (new_value_i),
    .accept_budget_i     (accept_budget_i),
    .accepted_o          (accepted_o),
    .site_spin_o         (site_spin_o),
    .bond_energy_o       (bond_energy_o),
    .magnet_total_o      (magnet_total_o),
    .square_total_o      (square_total_o),
    .total_energy_o      (total_energy_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/spm_ctrl.sv
// spm_ctrl: sequencer for lattice clear, neighbor reads, commit and result hand-off.
// Depends on spm_pkg; drives spm_dp through ctrl_cmd_t.
`default_nettype none

module spm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire spm_pkg::dp_status_t status_i,
  output spm_pkg::ctrl_cmd_t       cmd_o
);

  spm_pkg::state_e                state_q, state_d;
  logic [spm_pkg::ADDR_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic                           out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spm_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    clr_cnt_d      = clr_cnt_q;
    cmd_o          = '0;
    cmd_o.rd_sel   = spm_pkg::RD_SITE;
    cmd_o.clr_addr = clr_cnt_q;
    in_stall_o     = 1'b1;

    unique case (state_q)
      spm_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        clr_cnt_d    = clr_cnt_q + 1'b1;
        if (clr_cnt_q == spm_pkg::ADDR_W'(spm_pkg::SITE_COUNT - 1)) begin
          state_d = spm_pkg::ST_IDLE;
        end
      end
      spm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = spm_pkg::ST_DIV;
        end
      end
      spm_pkg::ST_DIV: begin
        cmd_o.rd_en  = status_i.in_range;
        cmd_o.rd_sel = spm_pkg::RD_SITE;
        cmd_o.div    = 1'b1;
        state_d      = status_i.in_range ? spm_pkg::ST_MOD : spm_pkg::ST_TOTAL;
      end
      spm_pkg::ST_MOD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = spm_pkg::RD_UP;
        cmd_o.mod    = 1'b1;
        state_d      = spm_pkg::ST_RD_DN;
      end
      spm_pkg::ST_RD_DN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = spm_pkg::RD_DN;
        state_d      = spm_pkg::ST_RD_LF;
      end
      spm_pkg::ST_RD_LF: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = spm_pkg::RD_LF;
        state_d      = spm_pkg::ST_RD_RT;
      end
      spm_pkg::ST_RD_RT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = spm_pkg::RD_RT;
        state_d      = spm_pkg::ST_EVAL;
      end
      spm_pkg::ST_EVAL: begin
        // last neighbor lands in the accumulator here
        state_d = spm_pkg::ST_COMMIT;
      end
      spm_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = spm_pkg::ST_TOTAL;
      end
      spm_pkg::ST_TOTAL: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = spm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/spm_dp.sv
// spm_dp: lattice memory, neighbor accumulation, energy test, running sums, result register.
// Depends on spm_pkg; sequenced by spm_ctrl.
`default_nettype none

module spm_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire spm_pkg::ctrl_cmd_t                   cmd_i,
  output spm_pkg::dp_status_t                       status_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic signed [spm_pkg::CF_W-1:0]      cfg_crystal_field_i,
  input  wire logic                                 action_i,
  input  wire logic [spm_pkg::SITE_W-1:0]           site_i,
  input  wire logic                                 proposal_pick_i,
  input  wire logic signed [spm_pkg::SPIN_W-1:0]    new_value_i,
  input  wire logic [spm_pkg::BUDGET_W-1:0]         accept_budget_i,
  output logic                                      accepted_o,
  output logic signed [spm_pkg::SPIN_W-1:0]         site_spin_o,
  output logic signed [spm_pkg::BOND_OUT_W-1:0]     bond_energy_o,
  output logic signed [spm_pkg::MAG_OUT_W-1:0]      magnet_total_o,
  output logic [spm_pkg::SQ_OUT_W-1:0]              square_total_o,
  output logic signed [spm_pkg::TOT_OUT_W-1:0]      total_energy_o
);

  localparam int PROD_W = spm_pkg::ADDR_W + spm_pkg::RECIP_W;

  // lattice
  logic signed [spm_pkg::SPIN_W-1:0] spin_mem [spm_pkg::SITE_COUNT];
  logic signed [spm_pkg::SPIN_W-1:0] rd_data_q;
  logic [spm_pkg::ADDR_W-1:0]        rd_addr, wr_addr;
  logic signed [spm_pkg::SPIN_W-1:0] wr_data;
  logic                              wr_en;

  // latched request
  logic                              action_q, pick_q;
  logic [spm_pkg::SITE_W-1:0]        site_q;
  logic signed [spm_pkg::SPIN_W-1:0] new_value_q;
  logic [spm_pkg::BUDGET_W-1:0]      budget_q;
  logic signed [spm_pkg::CF_W-1:0]   cf_q;

  logic [spm_pkg::ADDR_W-1:0]        addr;
  logic [PROD_W-1:0]                 div_prod;
  logic [spm_pkg::COL_W-1:0]         row_q;
  logic [spm_pkg::ADDR_W-1:0]        col_raw, col_fix;
  logic                              col_first_q, col_last_q;
  logic                              row_first, row_last;

  logic                              cap_vld_q, cap_site_q;
  logic signed [spm_pkg::SPIN_W-1:0] old_q;
  logic signed [3:0]                 nsum_q;

  // move evaluation
  logic signed [spm_pkg::SPIN_W-1:0] nv;
  logic signed [2:0]                 dv;
  logic signed [6:0]                 bprod, bchg;
  logic signed [1:0]                 sqd;
  logic signed [spm_pkg::DE_W-1:0]   de, field_part, budget_ext;
  logic                              take;

  logic                              accepted_q;
  logic signed [spm_pkg::SPIN_W-1:0] spin_q;
  logic signed [spm_pkg::BOND_W-1:0] bond_q;
  logic signed [spm_pkg::MAG_W-1:0]  mag_q;
  logic [spm_pkg::SQ_W-1:0]          sq_q;

  logic signed [spm_pkg::CF_W+spm_pkg::SQ_W:0] field_prod;
  logic signed [spm_pkg::TOT_INT_W-1:0]        tot_full;

  assign addr              = spm_pkg::ADDR_W'(site_q);
  assign status_o.in_range = 32'(site_q) < 32'(spm_pkg::SITE_COUNT);

  assign row_first = addr < spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE);
  assign row_last  = addr >= spm_pkg::ADDR_W'(spm_pkg::SITE_COUNT - spm_pkg::LATTICE_SIDE);

  // row by reciprocal, column by remainder with one correction step
  assign div_prod = addr * spm_pkg::RECIP_W'(spm_pkg::RECIP);
  assign col_raw  = addr - spm_pkg::ADDR_W'(row_q) * spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE);
  assign col_fix  = (col_raw >= spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE)) ?
                    col_raw - spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE) : col_raw;

  always_comb begin
    unique case (cmd_i.rd_sel)
      spm_pkg::RD_SITE: rd_addr = addr;
      spm_pkg::RD_UP: rd_addr = row_first ?
        addr + spm_pkg::ADDR_W'((spm_pkg::LATTICE_SIDE - 1) * spm_pkg::LATTICE_SIDE) :
        addr - spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE);
      spm_pkg::RD_DN: rd_addr = row_last ?
        addr - spm_pkg::ADDR_W'((spm_pkg::LATTICE_SIDE - 1) * spm_pkg::LATTICE_SIDE) :
        addr + spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE);
      spm_pkg::RD_LF: rd_addr = col_first_q ?
        addr + spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE - 1) : addr - 1'b1;
      spm_pkg::RD_RT: rd_addr = col_last_q ?
        addr - spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE - 1) : addr + 1'b1;
      default: rd_addr = addr;
    endcase
  end

  // proposal and energy change
  always_comb begin
    nv         = action_q ? new_value_q : spm_pkg::pick_spin(old_q, pick_q);
    dv         = 3'(nv) - 3'(old_q);
    bprod      = 7'(dv) * 7'(nsum_q);
    bchg       = -bprod;
    sqd        = $signed({1'b0, nv != 2'sb00}) - $signed({1'b0, old_q != 2'sb00});
    field_part = (sqd == 2'sb01) ? spm_pkg::DE_W'(cf_q) :
                 (sqd == 2'sb11) ? -spm_pkg::DE_W'(cf_q) : '0;
    de         = (spm_pkg::DE_W'(bchg) <<< 8) + field_part;
    budget_ext = $signed({3'b000, budget_q});
    if (action_q) begin
      take = (new_value_q != spm_pkg::SPIN_UNUSED) && (new_value_q != old_q);
    end else begin
      take = de <= budget_ext;
    end
  end

  assign wr_en   = cmd_i.clr_en || (cmd_i.commit && take);
  assign wr_addr = cmd_i.clr_en ? cmd_i.clr_addr : addr;
  assign wr_data = cmd_i.clr_en ? spm_pkg::SPIN_UP : nv;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      spin_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= spin_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q    <= action_i;
      site_q      <= site_i;
      pick_q      <= proposal_pick_i;
      new_value_q <= new_value_i;
      budget_q    <= accept_budget_i;
    end
    if (cmd_i.div) begin
      row_q <= div_prod[spm_pkg::DIV_K +: spm_pkg::COL_W];
    end
    if (cmd_i.mod) begin
      col_first_q <= col_fix == '0;
      col_last_q  <= col_fix == spm_pkg::ADDR_W'(spm_pkg::LATTICE_SIDE - 1);
    end
  end

  // read data returns in the cycle after the address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_vld_q  <= 1'b0;
      cap_site_q <= 1'b0;
    end else begin
      cap_vld_q  <= cmd_i.rd_en;
      cap_site_q <= cmd_i.rd_sel == spm_pkg::RD_SITE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nsum_q     <= '0;
      accepted_q <= 1'b0;
      spin_q     <= '0;
    end else begin
      if (cap_vld_q && cap_site_q) begin
        old_q <= rd_data_q;
      end
      if (cap_vld_q && !cap_site_q) begin
        nsum_q <= nsum_q + 4'(rd_data_q);
      end
      if (cmd_i.commit) begin
        accepted_q <= take;
        spin_q     <= take ? nv : old_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bond_q <= spm_pkg::BOND_RST;
      mag_q  <= spm_pkg::MAG_RST;
      sq_q   <= spm_pkg::SQ_RST;
      cf_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cf_q <= cfg_crystal_field_i;
      end
      if (cmd_i.commit && take) begin
        bond_q <= bond_q + spm_pkg::BOND_W'(bchg);
        mag_q  <= mag_q + spm_pkg::MAG_W'(dv);
        sq_q   <= sq_q + spm_pkg::SQ_W'(sqd);
      end
    end
  end

  // total = bond * 256 + D * squares; D is Q8.8, the 29-bit output Q21.8
  assign field_prod = cf_q * $signed({1'b0, sq_q});
  assign tot_full   = (spm_pkg::TOT_INT_W'(bond_q) <<< 8) + spm_pkg::TOT_INT_W'(field_prod);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      accepted_o     <= accepted_q;
      site_spin_o    <= spin_q;
      bond_energy_o  <= spm_pkg::BOND_OUT_W'(bond_q);
      magnet_total_o <= spm_pkg::MAG_OUT_W'(mag_q);
      square_total_o <= spm_pkg::SQ_OUT_W'(sq_q);
      total_energy_o <= spm_pkg::TOT_OUT_W'(tot_full);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/spm_chk.sv
// spm_chk: port-level checks on the result channel, bound to the top level.
// Depends on spm_pkg and spin_one_metropolis_update_top.
`default_nettype none

module spm_chk (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic                               accepted_o,
  input wire logic signed [spm_pkg::SPIN_W-1:0]  site_spin_o,
  input wire logic signed [spm_pkg::MAG_OUT_W-1:0] magnet_total_o,
  input wire logic [spm_pkg::SQ_OUT_W-1:0]       square_total_o,
  input wire logic signed [spm_pkg::TOT_OUT_W-1:0] total_energy_o
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_energy_o) &&
    $stable(accepted_o))
    else $error("stalled result dropped or changed");

  // the unused spin pattern never shows
  a_spin_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> site_spin_o != spm_pkg::SPIN_UNUSED)
    else $error("site spin holds unused pattern");

  // on every valid result |M| <= squares
  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed({2'b00, square_total_o}) >= 15'(magnet_total_o)) &&
                    ($signed({2'b00, square_total_o}) >= -15'(magnet_total_o)))
    else $error("magnetization exceeds square total");

  // an accepted result with spin 0 cannot report a full square total
  a_acc_spin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o && site_spin_o == 2'sb00 |-> square_total_o !=
    spm_pkg::SQ_OUT_W'(spm_pkg::SITE_COUNT))
    else $error("zero spin accepted but square total still full");

endmodule

bind spin_one_metropolis_update_top spm_chk u_spm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .accepted_o     (accepted_o),
  .site_spin_o    (site_spin_o),
  .magnet_total_o (magnet_total_o),
  .square_total_o (square_total_o),
  .total_energy_o (total_energy_o)
);

`default_nettype wire
